[design/adne_pkg.sv]
// adne_pkg: shared types, constants and the step position move table of the
// 4-bit ADPCM nibble encoder. No dependencies.
package adne_pkg;

  localparam logic [6:0] MAX_POSITION = 7'd88;
  localparam logic [6:0] STEP_BASE    = 7'd7;
  localparam logic [3:0] SIGN_BIT     = 4'b1000;

  // Encoder state carried from one sample to the next
  typedef struct packed {
    logic signed [15:0] predictor;
    logic [6:0]         position;
  } enc_state_t;

  // Step position move by magnitude bits (standard IMA index table)
  function automatic logic signed [4:0] position_move(input logic [2:0] mag);
    logic signed [4:0] mv;
    unique case (mag)
      3'd0, 3'd1, 3'd2, 3'd3: mv = -5'sd1;
      3'd4:                   mv = 5'sd2;
      3'd5:                   mv = 5'sd4;
      3'd6:                   mv = 5'sd6;
      3'd7:                   mv = 5'sd8;
      default:                mv = -5'sd1;
    endcase
    return mv;
  endfunction

endpackage

[design/adne_core.sv]
// adne_core: combinational encode of one sample against the current state,
// giving the 4-bit code and the next predictor and step position.
// Depends on adne_pkg.
module adne_core (
  input  logic signed [15:0]   sample,
  input  adne_pkg::enc_state_t state_cur,
  output adne_pkg::enc_state_t state_nxt,
  output logic [3:0]           code
);

  logic [6:0]         pos;
  logic [6:0]         step;
  logic signed [16:0] diff;
  logic               neg;
  logic [16:0]        dabs;
  logic [16:0]        rem1;
  logic [16:0]        rem2;
  logic [2:0]         mag;
  logic signed [8:0]  pos_sum;
  logic [7:0]         recon;
  logic signed [17:0] pred_sum;
  logic signed [4:0]  mv;

  // Step from the clamped position
  assign pos  = (state_cur.position > adne_pkg::MAX_POSITION) ? adne_pkg::MAX_POSITION
                                                               : state_cur.position;
  assign step = pos + adne_pkg::STEP_BASE;

  // Difference at 17 bits, split into sign and magnitude
  assign diff = {sample[15], sample} - {state_cur.predictor[15], state_cur.predictor};
  assign neg  = diff[16];
  assign dabs = neg ? 17'(-diff) : 17'(diff);

  // Successive compares against step, step/2, step/4
  always_comb begin
    mag[2] = (dabs >= {10'd0, step});
    rem1   = mag[2] ? (dabs - {10'd0, step}) : dabs;
    mag[1] = (rem1 >= {11'd0, step[6:1]});
    rem2   = mag[1] ? (rem1 - {11'd0, step[6:1]}) : rem1;
    mag[0] = (rem2 >= {12'd0, step[6:2]});
  end

  assign code = (neg ? adne_pkg::SIGN_BIT : 4'd0) | {1'b0, mag};

  // Advance and clamp the step position
  assign mv      = adne_pkg::position_move(mag);
  assign pos_sum = $signed({2'b00, pos}) + {{4{mv[4]}}, mv};

  always_comb begin
    priority if (pos_sum < 0) begin
      state_nxt.position = 7'd0;
    end else if (pos_sum > $signed({2'b00, adne_pkg::MAX_POSITION})) begin
      state_nxt.position = adne_pkg::MAX_POSITION;
    end else begin
      state_nxt.position = pos_sum[6:0];
    end
  end

  // Reconstructed difference and saturating predictor update
  assign recon = {4'd0, step[6:3]}
               + (mag[2] ? {1'b0, step} : 8'd0)
               + (mag[1] ? {2'b00, step[6:1]} : 8'd0)
               + (mag[0] ? {3'b000, step[6:2]} : 8'd0);

  assign pred_sum = neg ? ({{2{state_cur.predictor[15]}}, state_cur.predictor} - {10'd0, recon})
                        : ({{2{state_cur.predictor[15]}}, state_cur.predictor} + {10'd0, recon});

  always_comb begin
    priority if (!pred_sum[17] && (pred_sum[16:15] != 2'b00)) begin
      state_nxt.predictor = 16'sh7FFF;
    end else if (pred_sum[17] && (pred_sum[16:15] != 2'b11)) begin
      state_nxt.predictor = -16'sh8000;
    end else begin
      state_nxt.predictor = pred_sum[15:0];
    end
  end

endmodule

[design/adpcm_nibble_encoder.sv]
// adpcm_nibble_encoder: top level of the 4-bit ADPCM encoder with nibble packing.
// Depends on adne_pkg and adne_core.
//
//   channel | dir | tdata                    | tlast
//   in_     | in  | [15:0] sample (signed)   | end_of_block
//   out_    | out | [7:0]  code_byte         | block_end
//
// One sample per cycle while the output is not stalled; a sample is coded while it
// sits in the input register, and its byte is registered on the output as it moves on.
// The predictor and step position registers take their new values as a coded sample moves on.
// Reset clears the encoder state, the held nibble and both valid flags.
// A stalled output only holds back a sample that completes a byte.
module adpcm_nibble_encoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] sample
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] code_byte
  output logic        out_tlast
);

  logic                 in_valid_r;
  logic signed [15:0]   sample_r;
  logic                 eob_r;
  adne_pkg::enc_state_t state_r;
  adne_pkg::enc_state_t state_nxt;
  logic [3:0]           held_r;
  logic                 half_full_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_last_r;
  logic [3:0]           code;
  logic                 produces;
  logic                 out_free;
  logic                 advance;

  adne_core u_core (
    .sample    (sample_r),
    .state_cur (state_r),
    .state_nxt (state_nxt),
    .code      (code)
  );

  // Handshake: a sample moves on unless it needs the busy output register
  assign produces  = half_full_r | eob_r;
  assign out_free  = !out_valid_r | out_tready;
  assign advance   = in_valid_r & (!produces | out_free);
  assign in_tready = !in_valid_r | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
    if (in_tready && in_tvalid) begin
      sample_r <= in_tdata;
      eob_r    <= in_tlast;
    end
  end

  // Encoder state and nibble packing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      held_r      <= 4'd0;
      half_full_r <= 1'b0;
    end else if (advance) begin
      state_r <= state_nxt;
      if (produces) begin
        held_r      <= 4'd0;
        half_full_r <= 1'b0;
      end else begin
        held_r      <= code;
        half_full_r <= 1'b1;
      end
    end
  end

  // Output register: load a finished byte, drop it once transferred
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && produces) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (advance && produces) begin
      out_byte_r <= half_full_r ? {held_r, code} : {code, 4'd0};
      out_last_r <= half_full_r ? eob_r : 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_position_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.position <= adne_pkg::MAX_POSITION)
    else $error("step position above maximum");

  a_hold_first: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !half_full_r && !eob_r |=> half_full_r)
    else $error("first nibble not held");

  a_flush_lone: assert property (@(posedge clk) disable iff (!rst_n)
    advance && !half_full_r && eob_r |=> out_valid_r && out_last_r && out_byte_r[3:0] == 4'd0)
    else $error("lone nibble flush malformed");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !advance |-> out_valid_r && !out_tready && produces)
    else $error("sample stalled without output back-pressure");
`endif

endmodule

[test/adpcm_nibble_encoder_tb.sv]
// adpcm_nibble_encoder_tb: self-checking testbench for the 4-bit ADPCM nibble encoder.
// Streams directed and random sample runs with random gaps and output stalls, and
// compares every code byte with a behavioral predictor. Depends on adne_pkg and the RTL.
module adpcm_nibble_encoder_tb;

  localparam int MAX_POS      = int'(adne_pkg::MAX_POSITION);
  localparam int STEP_OFFSET  = int'(adne_pkg::STEP_BASE);
  localparam int SAMPLE_COUNT = 1100;
  localparam int QUIET_TAIL   = 150;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       block_end;
  } coded_byte_t;

  // Predicts the packed code bytes and checks the ones the encoder emits
  class adpcm_scoreboard;
    coded_byte_t expected_bytes[$];
    int          predictor;
    int          position;
    logic [3:0]  held_code;
    bit          holding;
    int          mismatches;
    int          bytes_seen;
    int          block_ends;
    int          saturations;
    int          top_positions;

    function new();
      predictor     = 0;
      position      = 0;
      held_code     = '0;
      holding       = 1'b0;
      mismatches    = 0;
      bytes_seen    = 0;
      block_ends    = 0;
      saturations   = 0;
      top_positions = 0;
    endfunction

    function int pending();
      return expected_bytes.size();
    endfunction

    // Code one accepted sample, advance the encoder state, queue any finished byte
    function void note_sample(logic signed [15:0] sample, logic end_of_block);
      int          step;
      int          diff;
      int          t;
      int          recon;
      logic [2:0]  mag;
      logic [3:0]  code;
      coded_byte_t b;
      step = position + STEP_OFFSET;
      diff = int'(sample) - predictor;
      code = '0;
      mag  = '0;
      if (diff < 0) begin
        code = adne_pkg::SIGN_BIT;
        diff = -diff;
      end
      t = step;
      if (diff >= t) begin
        mag[2] = 1'b1;
        diff  -= t;
      end
      t = t >>> 1;
      if (diff >= t) begin
        mag[1] = 1'b1;
        diff  -= t;
      end
      t = t >>> 1;
      if (diff >= t) mag[0] = 1'b1;

      // Move the step position by the magnitude and clamp it
      case (mag)
        3'd4:    position += 2;
        3'd5:    position += 4;
        3'd6:    position += 6;
        3'd7:    position += 8;
        default: position -= 1;
      endcase
      if (position < 0) position = 0;
      if (position >= MAX_POS) begin
        position = MAX_POS;
        top_positions++;
      end

      // Rebuild the difference and saturate the predictor to 16 bits
      recon = step >>> 3;
      if (mag[2]) recon += step;
      if (mag[1]) recon += step >>> 1;
      if (mag[0]) recon += step >>> 2;
      if (code[3]) predictor -= recon;
      else predictor += recon;
      if (predictor > 32767) begin
        predictor = 32767;
        saturations++;
      end
      if (predictor < -32768) begin
        predictor = -32768;
        saturations++;
      end
      code = code | {1'b0, mag};

      // Pack two codes per byte, earlier code in the high nibble
      if (!holding) begin
        if (end_of_block) begin
          b.code_byte = {code, 4'h0};
          b.block_end = 1'b1;
          expected_bytes.push_back(b);
        end else begin
          held_code = code;
          holding   = 1'b1;
        end
      end else begin
        b.code_byte = {held_code, code};
        b.block_end = end_of_block;
        expected_bytes.push_back(b);
        held_code = '0;
        holding   = 1'b0;
      end
    endfunction

    // Compare one emitted byte with the oldest expected byte
    function void check_byte(logic [7:0] code_byte, logic block_end);
      coded_byte_t b;
      bytes_seen++;
      if (block_end) block_ends++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected byte: code_byte 0x%02h block_end %0b", code_byte, block_end);
        mismatches++;
        return;
      end
      b = expected_bytes.pop_front();
      if (code_byte !== b.code_byte) begin
        $error("code_byte: expected 0x%02h, got 0x%02h", b.code_byte, code_byte);
        mismatches++;
      end
      if (block_end !== b.block_end) begin
        $error("block_end: expected %0b, got %0b", b.block_end, block_end);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata   = '0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;

  adpcm_scoreboard sb = new();
  bit              quiet;
  int              gap_pct;
  int              samples_sent;
  int              cycle_count;

  adpcm_nibble_encoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Watch both channels and feed every transfer to the scoreboard
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.note_sample(in_tdata, in_tlast);
      if (out_tvalid && out_tready) sb.check_byte(out_tdata, out_tlast);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stall the output in random bursts, never in the quiet tail
  initial begin
    forever begin
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (!quiet) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end
    end
  end

  function automatic int pick_gap();
    if (quiet || gap_pct == 0) return 0;
    if ($urandom_range(0, 99) < gap_pct) return $urandom_range(1, 9);
    return 0;
  endfunction

  // Present one sample and hold it until the transfer
  task automatic send_sample(input logic signed [15:0] sample, input logic end_of_block);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= sample;
    in_tlast  <= end_of_block;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    samples_sent++;
    if (samples_sent >= SAMPLE_COUNT - QUIET_TAIL) quiet = 1'b1;
  endtask

  initial begin
    int kind;
    int run_len;
    int amp;
    int level;
    logic eob;
    quiet        = 1'b0;
    gap_pct      = 30;
    samples_sent = 0;
    cycle_count  = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero difference at the bottom position, flushes, full-scale swings
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd0, 1'b1);          // second code closes a block
    send_sample(16'sd5, 1'b1);          // lone code flushed with a zero low nibble
    send_sample(16'sd32767, 1'b0);
    send_sample(-16'sd32768, 1'b0);
    // alternate the rails to drive the step position into its upper clamp
    for (int i = 0; i < 12; i++) send_sample(i[0] ? -16'sd32768 : 16'sd32767, 1'b0);
    send_sample(-16'sd1, 1'b0);
    send_sample(16'sd1, 1'b1);
    send_sample(16'sd100, 1'b1);
    send_sample(-16'sd100, 1'b0);
    send_sample(16'sd0, 1'b0);
    send_sample(16'sd32767, 1'b1);
    send_sample(-16'sd32768, 1'b0);
    send_sample(16'sd1, 1'b0);

    // Random runs: audio-like walks, rail runs that saturate, and raw noise
    level = 0;
    while (samples_sent < SAMPLE_COUNT) begin
      kind    = $urandom_range(0, 99);
      gap_pct = $urandom_range(0, 2) == 0 ? 0 : 25;
      if (kind < 50) begin
        run_len = $urandom_range(20, 80);
        case ($urandom_range(0, 3))
          0:       amp = 8;
          1:       amp = 64;
          2:       amp = 512;
          default: amp = 4096;
        endcase
      end else if (kind < 65) begin
        run_len = $urandom_range(150, 380);
        level   = $urandom_range(0, 1) ? 32767 : -32768;
      end else begin
        run_len = $urandom_range(10, 40);
      end
      for (int i = 0; i < run_len && samples_sent < SAMPLE_COUNT; i++) begin
        if (kind < 50) begin
          level = level + int'($urandom_range(0, 2 * amp)) - amp;
          if (level > 32767) level = 32767;
          if (level < -32768) level = -32768;
        end else if (kind >= 65) begin
          level = int'($urandom_range(0, 65535)) - 32768;
        end
        eob = (i == run_len - 1) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 11) == 0);
        send_sample(level[15:0], eob);
      end
    end
    in_tvalid <= 1'b0;

    // Drain the remaining bytes, then give the pipeline time to show strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d samples into %0d bytes, %0d of them closing a block",
             samples_sent, sb.bytes_seen, sb.block_ends);
    $display("predictor saturated %0d times, step position at its top %0d times",
             sb.saturations, sb.top_positions);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

[files.f]
design/adne_pkg.sv
design/adne_core.sv
design/adpcm_nibble_encoder.sv
test/adpcm_nibble_encoder_tb.sv
